/* hw/rtl/dual_encoder_speed_pid_core_macros.svh */
// Assertion macros shared by the dual encoder speed PID core.
`ifndef DUAL_ENCODER_SPEED_PID_CORE_MACROS_SVH
`define DUAL_ENCODER_SPEED_PID_CORE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked at every rising clock edge outside reset.
`define DSPID_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dspid assertion failed");
// Next-cycle implication, checked at every rising clock edge outside reset.
`define DSPID_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dspid assertion failed");
`else
`define DSPID_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSPID_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hw/rtl/dspid_pkg.sv */
// Package with widths, codes and types of the dual encoder speed PID core.
`timescale 1ns / 1ps
package dspid_pkg;

   // Fixed point and field widths.
   localparam int FRAC_BITS = 8;
   localparam int DUTY_MAX  = 255;
   localparam int DUTY_W    = 8;
   localparam int POS_W     = 32;
   localparam int GAIN_W    = 16;
   localparam int TGT_W     = 16;
   localparam int DT_W      = 16;
   localparam int ERR_W     = 24;
   localparam int SUM_W     = 32;
   localparam int FUNC_W    = 2;
   localparam int CSR_IDX_W = 3;

   // Divider: magnitude of the dividend and signed quotient.
   localparam int DIV_W = POS_W + FRAC_BITS;
   localparam int QUO_W = DIV_W + 1;
   localparam int CNT_W = $clog2(DIV_W + 1);

   // Shared multiplier: signed A by unsigned B.
   localparam int MUL_A_W = 48;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

   // Duty accumulator and the bound on the integral term.
   localparam int ACC_W    = 64;
   localparam int TERM_LOG = 60;

   localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(3 << FRAC_BITS);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_LEFT_ENC  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_RIGHT_ENC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CONTROL   = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_KP  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_KI  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEFT_KD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_KP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_KI = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_RIGHT_KD = 3'd5;

   // Track selectors.
   localparam logic TRK_LEFT  = 1'b0;
   localparam logic TRK_RIGHT = 1'b1;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_IDLE,
      S_SPEED,
      S_SPEED_WAIT,
      S_MUL_P,
      S_MUL_D,
      S_DIV_D,
      S_DIV_D_WAIT,
      S_MUL_I,
      S_ACC_I,
      S_UPDATE,
      S_RESP
   } state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* hw/rtl/dual_encoder_speed_pid_core.sv */
// An encoder item or a skipped control update goes straight to the response step.
// A control update with nonzero elapsed time first works through both tracks, left then right:
// per track two passes of the shared 40-step divider and the multiply, accumulate and update steps.
// The core takes one item at a time; the next item is taken the cycle after the result is registered.
// Reset (synchronous, active high) zeroes positions, duties and error history, restores the
// gains to their defaults and empties the result register.
`timescale 1ns / 1ps
`include "dual_encoder_speed_pid_core_macros.svh"
module dual_encoder_speed_pid_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [dspid_pkg::FUNC_W-1:0]           req_func,
   input  logic                                   req_phase_b,
   input  logic signed [dspid_pkg::TGT_W-1:0]     req_left_setpoint,
   input  logic signed [dspid_pkg::TGT_W-1:0]     req_right_setpoint,
   input  logic [dspid_pkg::DT_W-1:0]             req_elapsed_ms,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [dspid_pkg::DUTY_W-1:0]           rsp_left_duty,
   output logic [dspid_pkg::DUTY_W-1:0]           rsp_right_duty,
   output logic signed [dspid_pkg::POS_W-1:0]     rsp_left_count,
   output logic signed [dspid_pkg::POS_W-1:0]     rsp_right_count,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [dspid_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [dspid_pkg::GAIN_W-1:0]           csr_data
);
   import dspid_pkg::*;

   localparam logic signed [QUO_W:0] ERR_HI =
      {{(QUO_W - ERR_W + 2){1'b0}}, {(ERR_W - 1){1'b1}}};
   localparam logic signed [QUO_W:0] ERR_LO = ~ERR_HI;
   localparam logic signed [MUL_P_W-1:0] I_HI =
      {{(MUL_P_W - TERM_LOG){1'b0}}, {TERM_LOG{1'b0}}} | (MUL_P_W'(1) << TERM_LOG);
   localparam logic signed [MUL_P_W-1:0] I_LO = -I_HI;

   // Sequencer and per-track state.
   state_type                 state_ff, state_in;
   logic                      trk_ff, trk_in;
   logic [POS_W-1:0]          pos_ff [2];
   logic [POS_W-1:0]          pos_in [2];
   logic [POS_W-1:0]          prev_ff [2];
   logic [POS_W-1:0]          prev_in [2];
   logic [DUTY_W-1:0]         pwm_ff [2];
   logic [DUTY_W-1:0]         pwm_in [2];
   logic signed [ERR_W-1:0]   last_ff [2];
   logic signed [ERR_W-1:0]   last_in [2];
   logic signed [SUM_W-1:0]   sum_ff [2];
   logic signed [SUM_W-1:0]   sum_in [2];
   logic [GAIN_W-1:0]         kp_ff [2];
   logic [GAIN_W-1:0]         kp_in [2];
   logic [GAIN_W-1:0]         ki_ff [2];
   logic [GAIN_W-1:0]         ki_in [2];
   logic [GAIN_W-1:0]         kd_ff [2];
   logic [GAIN_W-1:0]         kd_in [2];

   // Working registers of one control update.
   logic signed [TGT_W-1:0]   tgt_ff [2];
   logic signed [TGT_W-1:0]   tgt_in [2];
   logic [DT_W-1:0]           dt_ff, dt_in;
   logic signed [ERR_W-1:0]   e_ff, e_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;

   // Result register.
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_load;
   logic [DUTY_W-1:0]         rsp_left_duty_ff, rsp_right_duty_ff;
   logic [POS_W-1:0]          rsp_left_count_ff, rsp_right_count_ff;

   // Datapath nets.
   logic                      req_fire;
   logic [POS_W-1:0]          delta;
   logic [POS_W-1:0]          delta_mag;
   logic [DIV_W-1:0]          div_dividend;
   logic                      div_neg;
   logic                      div_start;
   logic signed [QUO_W-1:0]   div_quotient;
   div_status_type            div_status;
   logic signed [QUO_W:0]     err_diff;
   logic signed [ERR_W-1:0]   err_sat;
   logic signed [ERR_W:0]     d_num;
   logic signed [QUO_W-1:0]   d_prod;
   logic [QUO_W-1:0]          d_mag;
   logic signed [MUL_P_W-1:0] i_sat;
   logic signed [ACC_W-1:0]   acc_shift;
   logic [DUTY_W-1:0]         duty_new;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   sum_sat;
   logic signed [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0]        mul_b;
   logic signed [MUL_P_W-1:0] product;

   assign req_fire  = req_valid & req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   // Speed numerator: wrapped position difference, split into sign and magnitude.
   assign delta     = pos_ff[trk_ff] - prev_ff[trk_ff];
   assign delta_mag = delta[POS_W-1] ? POS_W'(-delta) : delta;

   // Derivative numerator from the registered product, split into sign and magnitude.
   assign d_prod = product[QUO_W-1:0];
   assign d_mag  = d_prod[QUO_W-1] ? QUO_W'(-d_prod) : QUO_W'(d_prod);

   // The divider serves the speed in one pass and the derivative term in the other.
   assign div_start    = (state_ff == S_SPEED) || (state_ff == S_DIV_D);
   assign div_dividend = (state_ff == S_SPEED) ? (DIV_W'(delta_mag) << FRAC_BITS)
                                               : d_mag[DIV_W-1:0];
   assign div_neg      = (state_ff == S_SPEED) ? delta[POS_W-1] : d_prod[QUO_W-1];

   dspid_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .negative (div_neg),
      .divisor  (dt_ff),
      .quotient (div_quotient),
      .status   (div_status)
   );

   // Error: target minus measured speed, saturated to the error width.
   assign err_diff = (QUO_W + 1)'(tgt_ff[trk_ff]) - (QUO_W + 1)'(div_quotient);
   always_comb begin
      priority if (err_diff > ERR_HI) begin
         err_sat = ERR_HI[ERR_W-1:0];
      end else if (err_diff < ERR_LO) begin
         err_sat = ERR_LO[ERR_W-1:0];
      end else begin
         err_sat = err_diff[ERR_W-1:0];
      end
   end

   assign d_num = (ERR_W + 1)'(e_ff) - (ERR_W + 1)'(last_ff[trk_ff]);

   // Integral term bound keeps the accumulator from wrapping.
   always_comb begin
      priority if (product > I_HI) begin
         i_sat = I_HI;
      end else if (product < I_LO) begin
         i_sat = I_LO;
      end else begin
         i_sat = product;
      end
   end

   // New duty: drop the fraction and clamp to the duty range.
   assign acc_shift = acc_ff >>> (2 * FRAC_BITS);
   always_comb begin
      priority if (acc_ff[ACC_W-1]) begin
         duty_new = '0;
      end else if (acc_shift > ACC_W'(DUTY_MAX)) begin
         duty_new = DUTY_W'(DUTY_MAX);
      end else begin
         duty_new = acc_shift[DUTY_W-1:0];
      end
   end

   // Error sum with saturation.
   assign sum_wide = (SUM_W + 1)'(sum_ff[trk_ff]) + (SUM_W + 1)'(e_ff);
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                   : {1'b0, {(SUM_W - 1){1'b1}}};
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // Operand selection for the shared multiplier.
   always_comb begin
      unique case (state_ff)
         S_MUL_P: begin
            mul_a = MUL_A_W'(e_ff);
            mul_b = kp_ff[trk_ff];
         end
         S_MUL_D: begin
            mul_a = MUL_A_W'(d_num);
            mul_b = kd_ff[trk_ff];
         end
         S_DIV_D_WAIT: begin
            mul_a = MUL_A_W'(sum_ff[trk_ff]);
            mul_b = ki_ff[trk_ff];
         end
         S_MUL_I: begin
            mul_a = $signed(product[MUL_A_W-1:0]);
            mul_b = dt_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   dspid_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .product (product)
   );

   // Sequencer: next state and register updates.
   always_comb begin
      state_in = state_ff;
      trk_in   = trk_ff;
      pos_in   = pos_ff;
      prev_in  = prev_ff;
      pwm_in   = pwm_ff;
      last_in  = last_ff;
      sum_in   = sum_ff;
      kp_in    = kp_ff;
      ki_in    = ki_ff;
      kd_in    = kd_ff;
      tgt_in   = tgt_ff;
      dt_in    = dt_ff;
      e_in     = e_ff;
      acc_in   = acc_ff;
      rsp_load = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_RESP;
               unique case (req_func)
                  FUNC_LEFT_ENC, FUNC_RIGHT_ENC: begin
                     pos_in[req_func[0]] = req_phase_b ? pos_ff[req_func[0]] + 1'b1
                                                       : pos_ff[req_func[0]] - 1'b1;
                  end
                  FUNC_CONTROL: begin
                     if (req_elapsed_ms != '0) begin
                        tgt_in[TRK_LEFT]  = req_left_setpoint;
                        tgt_in[TRK_RIGHT] = req_right_setpoint;
                        dt_in             = req_elapsed_ms;
                        trk_in            = TRK_LEFT;
                        state_in          = S_SPEED;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SPEED: begin
            state_in = S_SPEED_WAIT;
         end
         S_SPEED_WAIT: begin
            if (div_status.done) begin
               e_in     = err_sat;
               acc_in   = ACC_W'(pwm_ff[trk_ff]) << (2 * FRAC_BITS);
               state_in = S_MUL_P;
            end
         end
         S_MUL_P: begin
            state_in = S_MUL_D;
         end
         S_MUL_D: begin
            acc_in   = acc_ff + ACC_W'(product);
            state_in = S_DIV_D;
         end
         S_DIV_D: begin
            state_in = S_DIV_D_WAIT;
         end
         S_DIV_D_WAIT: begin
            if (div_status.done) begin
               acc_in   = acc_ff + ACC_W'(div_quotient);
               state_in = S_MUL_I;
            end
         end
         S_MUL_I: begin
            state_in = S_ACC_I;
         end
         S_ACC_I: begin
            acc_in   = acc_ff + ACC_W'(i_sat);
            state_in = S_UPDATE;
         end
         S_UPDATE: begin
            pwm_in[trk_ff]  = duty_new;
            last_in[trk_ff] = e_ff;
            sum_in[trk_ff]  = sum_sat;
            prev_in[trk_ff] = pos_ff[trk_ff];
            if (trk_ff == TRK_RIGHT) begin
               state_in = S_RESP;
            end else begin
               trk_in   = TRK_RIGHT;
               state_in = S_SPEED;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Gain writes from the configuration port.
      if (csr_valid) begin
         unique case (csr_index)
            CSR_LEFT_KP:  kp_in[TRK_LEFT]  = csr_data;
            CSR_LEFT_KI:  ki_in[TRK_LEFT]  = csr_data;
            CSR_LEFT_KD:  kd_in[TRK_LEFT]  = csr_data;
            CSR_RIGHT_KP: kp_in[TRK_RIGHT] = csr_data;
            CSR_RIGHT_KI: ki_in[TRK_RIGHT] = csr_data;
            CSR_RIGHT_KD: kd_in[TRK_RIGHT] = csr_data;
            default: begin
               kp_in = kp_ff;
            end
         endcase
      end
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   // Control and track state with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         trk_ff       <= TRK_LEFT;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 2; k++) begin
            pos_ff[k]  <= '0;
            prev_ff[k] <= '0;
            pwm_ff[k]  <= '0;
            last_ff[k] <= '0;
            sum_ff[k]  <= '0;
            kp_ff[k]   <= KP_RESET;
            ki_ff[k]   <= '0;
            kd_ff[k]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         trk_ff       <= trk_in;
         rsp_valid_ff <= rsp_valid_in;
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         pwm_ff       <= pwm_in;
         last_ff      <= last_in;
         sum_ff       <= sum_in;
         kp_ff        <= kp_in;
         ki_ff        <= ki_in;
         kd_ff        <= kd_in;
      end
   end

   // Working and result payload registers.
   always_ff @(posedge clock) begin
      tgt_ff <= tgt_in;
      dt_ff  <= dt_in;
      e_ff   <= e_in;
      acc_ff <= acc_in;
      if (rsp_load) begin
         rsp_left_duty_ff   <= pwm_ff[TRK_LEFT];
         rsp_right_duty_ff  <= pwm_ff[TRK_RIGHT];
         rsp_left_count_ff  <= pos_ff[TRK_LEFT];
         rsp_right_count_ff <= pos_ff[TRK_RIGHT];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_left_duty   = rsp_left_duty_ff;
   assign rsp_right_duty  = rsp_right_duty_ff;
   assign rsp_left_count  = rsp_left_count_ff;
   assign rsp_right_count = rsp_right_count_ff;

   // The divider is started only when it is free.
   `DSPID_ASSERT_SAME(a_div_free, clock, reset, div_start, !div_status.busy && !div_status.done)
   // A finished division is always awaited by the sequencer.
   `DSPID_ASSERT_SAME(a_div_awaited, clock, reset, div_status.done, state_ff == S_SPEED_WAIT || state_ff == S_DIV_D_WAIT)
   // Positions hold while an item is being worked on.
   `DSPID_ASSERT_NEXT(a_pos_hold, clock, reset, state_ff != S_IDLE, $stable(pos_ff[0]) && $stable(pos_ff[1]))
   // A left encoder transaction moves the left count and leaves the right one alone.
   `DSPID_ASSERT_NEXT(a_left_enc, clock, reset, req_fire && req_func == FUNC_LEFT_ENC, $stable(pos_ff[1]) && pos_ff[0] != $past(pos_ff[0]))

endmodule

/* hw/rtl/dspid_mul.sv */
// Shared registered multiplier: signed operand times unsigned operand.
`timescale 1ns / 1ps
module dspid_mul (
   input  logic                                   clock,
   input  logic signed [dspid_pkg::MUL_A_W-1:0]   mul_a,
   input  logic        [dspid_pkg::MUL_B_W-1:0]   mul_b,
   output logic signed [dspid_pkg::MUL_P_W-1:0]   product
);
   import dspid_pkg::*;

   logic signed [MUL_B_W:0]   b_signed;
   logic signed [MUL_P_W-1:0] a_ext;
   logic signed [MUL_P_W-1:0] b_ext;
   logic signed [MUL_P_W-1:0] product_in;
   logic signed [MUL_P_W-1:0] product_ff;

   // Extend both operands to the product width and multiply.
   assign b_signed   = {1'b0, mul_b};
   assign a_ext      = MUL_P_W'(mul_a);
   assign b_ext      = MUL_P_W'(b_signed);
   assign product_in = a_ext * b_ext;

   // The product is registered before anything uses it.
   always_ff @(posedge clock) begin
      product_ff <= product_in;
   end

   assign product = product_ff;

endmodule

/* hw/rtl/dspid_div.sv */
// Shared restoring divider: one quotient bit per cycle, sign applied at the end.
`timescale 1ns / 1ps
module dspid_div (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [dspid_pkg::DIV_W-1:0]          dividend,
   input  logic                                 negative,
   input  logic [dspid_pkg::DT_W-1:0]           divisor,
   output logic signed [dspid_pkg::QUO_W-1:0]   quotient,
   output dspid_pkg::div_status_type            status
);
   import dspid_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    fix_ff, fix_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DIV_W-1:0]        quo_ff, quo_in;
   logic [DT_W-1:0]         rem_ff, rem_in;
   logic [DT_W-1:0]         dvs_ff, dvs_in;
   logic                    neg_ff, neg_in;
   logic signed [QUO_W-1:0] res_ff, res_in;
   logic [DT_W:0]           shifted;
   logic [DT_W+1:0]         trial;
   logic                    fits;

   // One trial subtraction of the shifted remainder.
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, dvs_ff};
   assign fits    = ~trial[DT_W+1];

   // Step control: load, iterate, apply the sign, flag completion.
   always_comb begin
      busy_in = busy_ff;
      fix_in  = 1'b0;
      done_in = fix_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      res_in  = res_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         quo_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
         neg_in  = negative;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], fits};
         rem_in = fits ? trial[DT_W-1:0] : shifted[DT_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            fix_in  = 1'b1;
         end
      end
      if (fix_ff) begin
         res_in = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fix_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         fix_ff  <= fix_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      res_ff <= res_in;
   end

   assign quotient    = res_ff;
   assign status.busy = busy_ff | fix_ff;
   assign status.done = done_ff;

endmodule
